### hw/rtl/periodic_gain_gate_macros.svh
// Assertion macros used by the periodic gain gate RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef PERIODIC_GAIN_GATE_MACROS_SVH
`define PERIODIC_GAIN_GATE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PGG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PGG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pgg_pkg.sv
// Package for the periodic gain gate: default widths, register indexes,
// phase codes and reset values. No dependencies.
package pgg_pkg;

  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int LENGTH_BITS_DEF    = 20;
  localparam int GAIN_FRAC_BITS_DEF = 47;

  localparam int FLOOR_BITS = 24;
  localparam int FLOOR_FRAC = 23;

  localparam int CFG_ADDR_BITS = 3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CEIL_LEN    = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_RELEASE_LEN = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FLOOR_LEN   = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ATTACK_LEN  = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FLOOR_GAIN  = 3'd4;

  typedef logic [1:0] phase_t;
  localparam phase_t PH_CEIL    = 2'd0;
  localparam phase_t PH_RELEASE = 2'd1;
  localparam phase_t PH_FLOOR   = 2'd2;
  localparam phase_t PH_ATTACK  = 2'd3;

  localparam int unsigned CEIL_LEN_RST    = 32'd5468;
  localparam int unsigned RELEASE_LEN_RST = 32'd44;
  localparam int unsigned FLOOR_LEN_RST   = 32'd5468;
  localparam int unsigned ATTACK_LEN_RST  = 32'd44;
  localparam logic [FLOOR_BITS-1:0] FLOOR_GAIN_RST = 24'd3339654;

endpackage

### hw/rtl/periodic_gain_gate.sv
// Periodic gain gate: multiplies each audio sample by a four-phase gain envelope.
// Depends on pgg_pkg and periodic_gain_gate_macros.svh.
//
// Usage: one request on the in_ channel carries a signed sample in in_tdata and
// a restart flag in in_tuser; one request on the out_ channel returns the gated
// sample. Registers are written through cfg_wen/cfg_addr/cfg_wdata while idle.
// Each request is handled alone by a sequencer around a serial divider and a
// bit-serial shift-add multiplier. Within a phase a request goes from acceptance
// through the multiplier to out_tvalid. On entry to a phase the sequencer first
// checks up to four phases in turn for a nonzero phase length, and if one is found a
// restoring divider works out the gain step before the multiplier runs.
// in_tready rises together with out_tvalid, so a new request is accepted only
// once the previous result has been moved into the output register.
// in_tready is high whenever the sequencer is idle, even while a result waits
// in the output register. If the receiver stalls, the next request finishes its
// arithmetic and then holds until the output register is taken.
// Reset sets the default register values, the ceiling phase and unity gain.
// No clearing pass is needed; the block accepts requests right after reset.
`include "periodic_gain_gate_macros.svh"

module periodic_gain_gate #(
  parameter int SAMPLE_BITS    = pgg_pkg::SAMPLE_BITS_DEF,
  parameter int LENGTH_BITS    = pgg_pkg::LENGTH_BITS_DEF,
  parameter int GAIN_FRAC_BITS = pgg_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,   // sample
  input  logic                                   in_tuser,   // restart
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]       out_tdata,  // gated_sample
  input  logic                                   cfg_wen,
  input  logic [pgg_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
  input  logic [(LENGTH_BITS > pgg_pkg::FLOOR_BITS ?
                 LENGTH_BITS : pgg_pkg::FLOOR_BITS)-1:0] cfg_wdata
);

  localparam int S      = SAMPLE_BITS;
  localparam int L      = LENGTH_BITS;
  localparam int GF     = GAIN_FRAC_BITS;
  localparam int G      = GAIN_FRAC_BITS + 1;
  localparam int FB     = pgg_pkg::FLOOR_BITS;
  localparam int DATA_W = ((SAMPLE_BITS+7)/8)*8;
  localparam int CNT_W  = $clog2((G > S ? G : S) + 1);
  localparam int FW_W   = G + FB;

  localparam logic [G-1:0] UNITY = {1'b1, {GF{1'b0}}};

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  pgg_pkg::phase_t      phase_r, phase_nxt;
  logic [L-1:0]         remaining_r, remaining_nxt;
  logic [G-1:0]         gain_r, gain_nxt;
  logic [G:0]           step_r, step_nxt;
  logic [G-1:0]         dvd_r, dvd_nxt;
  logic [L-1:0]         rem_r, rem_nxt;
  logic                 dneg_r, dneg_nxt;
  logic [S-1:0]         mag_r, mag_nxt;
  logic                 sneg_r, sneg_nxt;
  logic [S+G-1:0]       prod_r, prod_nxt;
  logic [S-1:0]         out_data_r, out_data_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [L-1:0]         ceil_len_r, ceil_len_nxt;
  logic [L-1:0]         rel_len_r, rel_len_nxt;
  logic [L-1:0]         floor_len_r, floor_len_nxt;
  logic [L-1:0]         att_len_r, att_len_nxt;
  logic [FB-1:0]        floor_gain_r, floor_gain_nxt;

  logic                 in_accept;
  logic [S-1:0]         raw;
  pgg_pkg::phase_t      phase_inc;
  logic [L-1:0]         inc_len;
  logic [L-1:0]         cur_len;
  logic [FB-1:0]        floor_clamped;
  logic [FW_W-1:0]      floor_wide;
  logic [G-1:0]         floor_g;
  logic [G-1:0]         target;
  logic [L:0]           trial;
  logic                 trial_ge;
  logic [L:0]           trial_diff;
  logic [G+1:0]         gain_sum;
  logic [S-1:0]         prod_hi;

  function automatic logic [L-1:0] len_of(input pgg_pkg::phase_t p,
                                          input logic [L-1:0] c,
                                          input logic [L-1:0] r,
                                          input logic [L-1:0] f,
                                          input logic [L-1:0] a);
    logic [L-1:0] v;
    case (p)
      pgg_pkg::PH_CEIL:    v = c;
      pgg_pkg::PH_RELEASE: v = r;
      pgg_pkg::PH_FLOOR:   v = f;
      default:             v = a;
    endcase
    return v;
  endfunction

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_data_r);
  assign raw        = in_tdata[S-1:0];

  assign phase_inc = phase_r + 2'd1;
  assign inc_len   = len_of(phase_inc, ceil_len_r, rel_len_r, floor_len_r, att_len_r);
  assign cur_len   = len_of(phase_r, ceil_len_r, rel_len_r, floor_len_r, att_len_r);

  // Floor gain is Q1.23; rescale to the gain format by constant shifts.
  assign floor_clamped = (floor_gain_r > FB'(1 << pgg_pkg::FLOOR_FRAC)) ?
                         FB'(1 << pgg_pkg::FLOOR_FRAC) : floor_gain_r;
  assign floor_wide    = (FW_W'(floor_clamped) << GF) >> pgg_pkg::FLOOR_FRAC;
  assign floor_g       = floor_wide[G-1:0];
  assign target        = (phase_inc == pgg_pkg::PH_RELEASE ||
                          phase_inc == pgg_pkg::PH_FLOOR) ? floor_g : UNITY;

  assign trial      = {rem_r, dvd_r[G-1]};
  assign trial_ge   = trial >= {1'b0, cur_len};
  assign trial_diff = trial - {1'b0, cur_len};

  assign gain_sum = {2'b00, gain_r} + {step_r[G], step_r};
  assign prod_hi  = prod_r[GF +: S];

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    phase_nxt      = phase_r;
    remaining_nxt  = remaining_r;
    gain_nxt       = gain_r;
    step_nxt       = step_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    dneg_nxt       = dneg_r;
    mag_nxt        = mag_r;
    sneg_nxt       = sneg_r;
    prod_nxt       = prod_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    ceil_len_nxt   = ceil_len_r;
    rel_len_nxt    = rel_len_r;
    floor_len_nxt  = floor_len_r;
    att_len_nxt    = att_len_r;
    floor_gain_nxt = floor_gain_r;

    if (cfg_wen) begin
      case (cfg_addr)
        pgg_pkg::REG_CEIL_LEN:    ceil_len_nxt   = cfg_wdata[L-1:0];
        pgg_pkg::REG_RELEASE_LEN: rel_len_nxt    = cfg_wdata[L-1:0];
        pgg_pkg::REG_FLOOR_LEN:   floor_len_nxt  = cfg_wdata[L-1:0];
        pgg_pkg::REG_ATTACK_LEN:  att_len_nxt    = cfg_wdata[L-1:0];
        pgg_pkg::REG_FLOOR_GAIN:  floor_gain_nxt = cfg_wdata[FB-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          sneg_nxt = raw[S-1];
          mag_nxt  = raw[S-1] ? (S'(0) - raw) : raw;
          prod_nxt = '0;
          if (in_tuser) begin
            phase_nxt     = pgg_pkg::PH_FLOOR;
            remaining_nxt = '0;
          end
          if (in_tuser || remaining_r == '0) begin
            cnt_nxt   = CNT_W'(3);
            state_nxt = ST_SEARCH;
          end else begin
            cnt_nxt   = CNT_W'(S - 1);
            state_nxt = ST_MUL;
          end
        end
      end
      ST_SEARCH: begin
        phase_nxt = phase_inc;
        if (inc_len != '0) begin
          remaining_nxt = inc_len;
          dneg_nxt      = !(target >= gain_r);
          dvd_nxt       = (target >= gain_r) ? (target - gain_r) : (gain_r - target);
          rem_nxt       = '0;
          cnt_nxt       = CNT_W'(G - 1);
          state_nxt     = ST_DIV;
        end else if (cnt_r == '0) begin
          remaining_nxt = '0;
          step_nxt      = '0;
          cnt_nxt       = CNT_W'(S - 1);
          state_nxt     = ST_MUL;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_DIV: begin
        rem_nxt = trial_ge ? trial_diff[L-1:0] : trial[L-1:0];
        dvd_nxt = {dvd_r[G-2:0], trial_ge};
        if (cnt_r == '0) begin
          step_nxt  = dneg_r ? ((G+1)'(0) - {1'b0, dvd_nxt}) : {1'b0, dvd_nxt};
          cnt_nxt   = CNT_W'(S - 1);
          state_nxt = ST_MUL;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_MUL: begin
        prod_nxt = {prod_r[S+G-2:0], 1'b0} + (mag_r[S-1] ? {{S{1'b0}}, gain_r} : '0);
        mag_nxt  = {mag_r[S-2:0], 1'b0};
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = sneg_r ? (S'(0) - prod_hi) : prod_hi;
          out_valid_nxt = 1'b1;
          if (gain_sum[G+1]) begin
            gain_nxt = '0;
          end else if (gain_sum[G:0] > {1'b0, UNITY}) begin
            gain_nxt = UNITY;
          end else begin
            gain_nxt = gain_sum[G-1:0];
          end
          if (remaining_r != '0) begin
            remaining_nxt = remaining_r - L'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      phase_r      <= pgg_pkg::PH_CEIL;
      remaining_r  <= L'(pgg_pkg::CEIL_LEN_RST);
      gain_r       <= UNITY;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
      ceil_len_r   <= L'(pgg_pkg::CEIL_LEN_RST);
      rel_len_r    <= L'(pgg_pkg::RELEASE_LEN_RST);
      floor_len_r  <= L'(pgg_pkg::FLOOR_LEN_RST);
      att_len_r    <= L'(pgg_pkg::ATTACK_LEN_RST);
      floor_gain_r <= pgg_pkg::FLOOR_GAIN_RST;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      phase_r      <= phase_nxt;
      remaining_r  <= remaining_nxt;
      gain_r       <= gain_nxt;
      step_r       <= step_nxt;
      out_valid_r  <= out_valid_nxt;
      ceil_len_r   <= ceil_len_nxt;
      rel_len_r    <= rel_len_nxt;
      floor_len_r  <= floor_len_nxt;
      att_len_r    <= att_len_nxt;
      floor_gain_r <= floor_gain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    dneg_r     <= dneg_nxt;
    mag_r      <= mag_nxt;
    sneg_r     <= sneg_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  `PGG_ASSERT_NEXT(a_busy_after_accept, in_accept, state_r != ST_IDLE, "Sequencer idle after a request was accepted.")
  `PGG_ASSERT_NOW(a_gain_in_range, 1'b1, gain_r <= UNITY, "Gain exceeds unity.")
  `PGG_ASSERT_NOW(a_div_nonzero_len, state_r == ST_DIV, cur_len != '0, "Division started on a zero phase length.")
  `PGG_ASSERT_NOW(a_out_from_fin, $rose(out_valid_r), $past(state_r) == ST_FIN, "Result appeared without finishing a request.")

endmodule

### bench/tb.sv
// Testbench for periodic_gain_gate: a directed table, then random samples and settings,
// with every gated sample checked against the table's expected value or an envelope predictor kept in the bench.
// Depends on pgg_pkg and the periodic_gain_gate RTL.
module tb;

  localparam int SB = pgg_pkg::SAMPLE_BITS_DEF;
  localparam int LB = pgg_pkg::LENGTH_BITS_DEF;
  localparam int GF = pgg_pkg::GAIN_FRAC_BITS_DEF;
  localparam int GW = GF + 1;
  localparam int DB = ((SB + 7) / 8) * 8;
  localparam int FBW = pgg_pkg::FLOOR_BITS;
  localparam int AW = pgg_pkg::CFG_ADDR_BITS;
  localparam int CW = (LB > FBW) ? LB : FBW;
  localparam int PADW = CW - LB;
  localparam logic [AW-1:0] REG_NONE = 3'd7;
  localparam logic [GW-1:0] UNITY = {1'b1, {GF{1'b0}}};
  localparam logic [CW-1:0] FLOOR_UNITY = CW'(1) << pgg_pkg::FLOOR_FRAC;
  localparam logic [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam int MAX_CYCLES = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 100;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [AW-1:0]            addr;
    logic [CW-1:0]            wdata;
    logic [SB-1:0]            smp;
    logic                     restart;
    logic                     known;
    logic [SB-1:0]            want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DB-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DB-1:0] out_tdata;
  logic cfg_wen = 1'b0;
  logic [AW-1:0] cfg_addr = '0;
  logic [CW-1:0] cfg_wdata = '0;

  logic [LB-1:0] len_reg [4];
  logic [FBW-1:0] floor_reg;
  pgg_pkg::phase_t env_phase;
  logic [LB-1:0] env_left;
  logic [GW-1:0] env_gain;
  longint env_step;

  logic [SB-1:0] gated_q [$];
  logic [SB-1:0] gated_head;
  plan_row_t plan [$];
  int mismatches = 0;
  int cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  periodic_gain_gate uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),     // sample
    .in_tuser(in_tuser),     // restart
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),   // gated_sample
    .cfg_wen(cfg_wen),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void env_config(logic [AW-1:0] addr, logic [CW-1:0] wdata);
    case (addr)
      pgg_pkg::REG_CEIL_LEN:    len_reg[pgg_pkg::PH_CEIL] = wdata[LB-1:0];
      pgg_pkg::REG_RELEASE_LEN: len_reg[pgg_pkg::PH_RELEASE] = wdata[LB-1:0];
      pgg_pkg::REG_FLOOR_LEN:   len_reg[pgg_pkg::PH_FLOOR] = wdata[LB-1:0];
      pgg_pkg::REG_ATTACK_LEN:  len_reg[pgg_pkg::PH_ATTACK] = wdata[LB-1:0];
      pgg_pkg::REG_FLOOR_GAIN:  floor_reg = wdata[FBW-1:0];
      default: ;
    endcase
  endfunction

  // Moves to the next phase with a nonzero length and sets up its linear ramp, or holds the gain if none.
  function automatic void env_enter_phase();
    logic [FBW-1:0] f;
    logic [GW-1:0] target;
    logic [LB-1:0] len;
    for (int k = 0; k < 4; k++) begin
      env_phase = pgg_pkg::phase_t'(env_phase + 2'd1);
      len = len_reg[env_phase];
      if (len != '0) begin
        f = floor_reg;
        if (f > FBW'(FLOOR_UNITY)) f = FBW'(FLOOR_UNITY);
        if (env_phase == pgg_pkg::PH_RELEASE || env_phase == pgg_pkg::PH_FLOOR) begin
          target = GW'(f) << (GF - pgg_pkg::FLOOR_FRAC);
        end else begin
          target = UNITY;
        end
        env_left = len;
        if (target >= env_gain) begin
          env_step = longint'((target - env_gain) / len);
        end else begin
          env_step = -longint'((env_gain - target) / len);
        end
        return;
      end
    end
    env_left = '0;
    env_step = 0;
  endfunction

  function automatic logic [SB-1:0] gate_sample(logic [SB-1:0] smp, logic restart);
    logic neg;
    logic [SB:0] mag;
    logic [63:0] prod;
    longint ng;
    neg = smp[SB-1];
    mag = neg ? ((SB+1)'(1) << SB) - {1'b0, smp} : {1'b0, smp};
    if (restart) begin
      env_phase = pgg_pkg::PH_FLOOR;
      env_left = '0;
    end
    if (env_left == '0) env_enter_phase();
    prod = (64'(mag) * 64'(env_gain)) >> GF;
    ng = longint'(env_gain) + env_step;
    if (ng < 0) ng = 0;
    if (ng > longint'(UNITY)) ng = longint'(UNITY);
    env_gain = GW'(ng);
    if (env_left != '0) env_left = env_left - 1'b1;
    return neg ? SB'(-prod) : SB'(prod);
  endfunction

  function automatic plan_row_t item_row(int smp, logic restart, logic known, int want);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.smp = SB'(smp);
    r.restart = restart;
    r.known = known;
    r.want = SB'(want);
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [AW-1:0] addr, logic [CW-1:0] wdata);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.addr = addr;
    r.wdata = wdata;
    return r;
  endfunction

  function automatic logic [CW-1:0] rand_len_word();
    logic [LB-1:0] len;
    case ($urandom_range(9))
      0: len = '0;
      1: len = LB'($urandom_range(200, 40));
      default: len = LB'($urandom_range(6, 1));
    endcase
    return {PADW'($urandom), len};
  endfunction

  function automatic logic [CW-1:0] rand_floor_word();
    case ($urandom_range(4))
      0: return '0;
      1: return FLOOR_UNITY;
      2: return CW'($urandom);
      default: return CW'($urandom_range(FLOOR_UNITY));
    endcase
  endfunction

  function automatic logic [SB-1:0] rand_sample();
    case ($urandom_range(7))
      0: return SMP_MIN;
      1: return SMP_MAX;
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (gated_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [AW-1:0] addr, logic [CW-1:0] wdata);
    wait_idle();
    cfg_wen <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= wdata;
    env_config(addr, wdata);
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // The valid is left high after acceptance so a following request can go back to back.
  task automatic send_item(logic [SB-1:0] smp, logic restart, logic known, logic [SB-1:0] want);
    logic [SB-1:0] model_out;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= DB'(smp);
    in_tuser <= restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model_out = gate_sample(smp, restart);
    gated_q.push_back(known ? want : model_out);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (gated_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected gated sample %0d", $signed(out_tdata[SB-1:0]));
          end
        end else begin
          gated_head = gated_q.pop_front();
          if (out_tdata[SB-1:0] !== gated_head) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("gated sample mismatch: expected %0d, got %0d",
                       $signed(gated_head), $signed(out_tdata[SB-1:0]));
            end
          end
        end
      end
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    len_reg[pgg_pkg::PH_CEIL] = LB'(pgg_pkg::CEIL_LEN_RST);
    len_reg[pgg_pkg::PH_RELEASE] = LB'(pgg_pkg::RELEASE_LEN_RST);
    len_reg[pgg_pkg::PH_FLOOR] = LB'(pgg_pkg::FLOOR_LEN_RST);
    len_reg[pgg_pkg::PH_ATTACK] = LB'(pgg_pkg::ATTACK_LEN_RST);
    floor_reg = pgg_pkg::FLOOR_GAIN_RST;
    env_phase = pgg_pkg::PH_CEIL;
    env_left = LB'(pgg_pkg::CEIL_LEN_RST);
    env_gain = UNITY;
    env_step = 0;

    plan = '{
      item_row(32767, 1'b0, 1'b1, 32767),
      item_row(-32768, 1'b0, 1'b1, -32768),
      item_row(0, 1'b0, 1'b1, 0),
      item_row(-1, 1'b0, 1'b1, -1),
      item_row(1, 1'b1, 1'b1, 1),
      cfg_row(pgg_pkg::REG_FLOOR_GAIN, '0),
      cfg_row(pgg_pkg::REG_CEIL_LEN, CW'(1)),
      cfg_row(pgg_pkg::REG_RELEASE_LEN, CW'(2)),
      cfg_row(pgg_pkg::REG_FLOOR_LEN, CW'(1)),
      cfg_row(pgg_pkg::REG_ATTACK_LEN, '0),
      item_row(12345, 1'b1, 1'b1, 12345),
      item_row(-20000, 1'b0, 1'b1, -20000),
      item_row(32767, 1'b0, 1'b1, 16383),
      item_row(-32768, 1'b0, 1'b1, 0),
      item_row(32767, 1'b0, 1'b1, 0),
      item_row(-32768, 1'b0, 1'b1, -32768),
      cfg_row(pgg_pkg::REG_CEIL_LEN, '0),
      cfg_row(pgg_pkg::REG_RELEASE_LEN, '0),
      cfg_row(pgg_pkg::REG_FLOOR_LEN, '0),
      item_row(-32768, 1'b0, 1'b1, -16384),
      item_row(32767, 1'b0, 1'b1, 0),
      item_row(-32768, 1'b1, 1'b1, 0),
      cfg_row(pgg_pkg::REG_FLOOR_GAIN, {CW{1'b1}}),
      cfg_row(pgg_pkg::REG_FLOOR_LEN, CW'(3)),
      item_row(-32768, 1'b0, 1'b1, 0),
      item_row(32767, 1'b0, 1'b0, 0),
      item_row(-32768, 1'b0, 1'b0, 0),
      cfg_row(REG_NONE, {CW{1'b1}}),
      cfg_row(pgg_pkg::REG_CEIL_LEN, {CW{1'b1}}),
      cfg_row(pgg_pkg::REG_RELEASE_LEN, CW'({LB{1'b1}})),
      cfg_row(pgg_pkg::REG_FLOOR_LEN, CW'({LB{1'b1}})),
      cfg_row(pgg_pkg::REG_ATTACK_LEN, CW'({LB{1'b1}})),
      cfg_row(pgg_pkg::REG_FLOOR_GAIN, FLOOR_UNITY),
      item_row(-32768, 1'b1, 1'b0, 0),
      item_row(32767, 1'b0, 1'b0, 0),
      item_row(-12345, 1'b0, 1'b0, 0)
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].addr, plan[i].wdata);
      end else begin
        send_item(plan[i].smp, plan[i].restart, plan[i].known, plan[i].want);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct = 11;
          rx_idle_pct = 87;
        end
        1: begin
          tx_idle_pct = 87;
          rx_idle_pct = 11;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        write_reg(pgg_pkg::REG_CEIL_LEN, rand_len_word());
        write_reg(pgg_pkg::REG_RELEASE_LEN, rand_len_word());
        write_reg(pgg_pkg::REG_FLOOR_LEN, rand_len_word());
        write_reg(pgg_pkg::REG_ATTACK_LEN, rand_len_word());
        write_reg(pgg_pkg::REG_FLOOR_GAIN, rand_floor_word());
        // A long receiver stall while requests keep coming fills the block up.
        if (seg == 1 && mode != 1) hold_asks++;
        for (int n = 0; n < 40; n++) begin
          if ($urandom_range(39) == 0) wait_idle();
          send_item(rand_sample(), $urandom_range(19) == 0, 1'b0, '0);
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && gated_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
